FILE: rtl/scalru_pkg.sv
// Shared types and codes for the set-associative LRU cache store.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package scalru_pkg;

   localparam int ADDR_BITS_DEF   = 48;
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int SET_COUNT_DEF   = 256;
   localparam int WAYS_DEF        = 4;

   localparam int AGE_W   = 8;
   localparam int Q_DEPTH = 2;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_MISS   = 2'd0;
   localparam kind_type KIND_HIT    = 2'd1;
   localparam kind_type KIND_COMMIT = 2'd2;

   typedef logic [1:0] op_type;
   localparam op_type OP_LOOKUP = 2'd0;
   localparam op_type OP_FILL   = 2'd1;
   localparam op_type OP_COMMIT = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [47:0] address;
      logic [2:0]  word_index;
      logic [63:0] word_data;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [9:0]  entry;
      logic [2:0]  out_word_index;
      logic [63:0] out_word;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } be_status_type;

endpackage

FILE: rtl/scalru_fifo.sv
// Two-entry register queue of a flat payload.
// Parts the front from the back and the back from the result port; uses scalru_pkg.
`timescale 1ns / 1ps

module scalru_fifo
   import scalru_pkg::*;
#(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty
);

   logic [W-1:0] mem_ff [Q_DEPTH];
   logic         wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = (cnt_ff == 2'(Q_DEPTH));
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/scalru_fe.sv
// Front end: takes request items and classifies them into back-end operations.
// Drops insert words beyond the line; uses scalru_pkg.
`timescale 1ns / 1ps

module scalru_fe
   import scalru_pkg::*;
#(
   parameter int LINE_WORDS = 8
) (
   input  logic    push,
   input  req_type req_data,
   input  logic    cq_full,
   input  logic    clearing,
   output logic    full,
   output logic    cq_push,
   output cmd_type cq_data
);

   logic accept, drop;

   assign full   = cq_full || clearing;
   assign accept = push && !full;

   always_comb begin
      cq_data.req = req_data;
      drop        = 1'b0;
      if (req_data.cmd == CMD_LOOKUP) begin
         cq_data.op = OP_LOOKUP;
      end else if (32'(req_data.word_index) >= LINE_WORDS) begin
         cq_data.op = OP_FILL;
         drop       = 1'b1;
      end else if (32'(req_data.word_index) == LINE_WORDS - 1) begin
         cq_data.op = OP_COMMIT;
      end else begin
         cq_data.op = OP_FILL;
      end
   end

   assign cq_push = accept && !drop;

endmodule

FILE: rtl/scalru_be.sv
// Back end: tag/age/valid memory, line data memory, fill buffer and sequencer.
// Runs lookups, fills and commits from the command queue; uses scalru_pkg.
`timescale 1ns / 1ps

module scalru_be
   import scalru_pkg::*;
#(
   parameter int ADDR_BITS   = ADDR_BITS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int SET_COUNT   = SET_COUNT_DEF,
   parameter int WAYS        = WAYS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cq_empty,
   input  cmd_type       cq_data,
   output logic          cq_pop,
   input  logic          rq_full,
   output logic          rq_push,
   output rsp_type       rq_data,
   output be_status_type status
);

   localparam int LINE_WORDS = BLOCK_BYTES / 8;
   localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
   localparam int LOG_SETS   = $clog2(SET_COUNT);
   localparam int SET_W      = (LOG_SETS > 0) ? LOG_SETS : 1;
   localparam int TAG_W      = ADDR_BITS - OFF_BITS - LOG_SETS;
   localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ENT_W      = (SET_COUNT * WAYS > 1) ? $clog2(SET_COUNT * WAYS) : 1;
   localparam int WIDX_W     = $clog2(LINE_WORDS);
   localparam int DADDR_W    = ENT_W + WIDX_W;

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_META = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_WR   = 3'd4;
   localparam logic [2:0] S_COPY = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   // set-wide rows of per-way metadata
   logic [WAYS-1:0]                   mvalid [SET_COUNT];
   logic [WAYS-1:0][AGE_W-1:0]        mage   [SET_COUNT];
   logic [WAYS-1:0][TAG_W-1:0]        mtag   [SET_COUNT];
   logic [63:0]                       dmem   [SET_COUNT * WAYS * LINE_WORDS];

   logic [WAYS-1:0]                   rvalid_ff;
   logic [WAYS-1:0][AGE_W-1:0]        rage_ff;
   logic [WAYS-1:0][TAG_W-1:0]        rtag_ff;
   logic [63:0]                       drd_ff;

   logic [2:0]        state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [ENT_W-1:0]  ent_ff, ent_in;
   logic [WIDX_W-1:0] k_ff, k_in;
   logic [SET_W-1:0]  clr_ff, clr_in;
   logic [63:0]       fb_ff [LINE_WORDS];

   logic [ADDR_BITS-1:0] q_addr, c_addr;
   logic [SET_W-1:0]     q_set, c_set, raddr, waddr;
   logic [TAG_W-1:0]     c_tag;

   logic                       mwe;
   logic [WAYS-1:0]            mw_valid;
   logic [WAYS-1:0][AGE_W-1:0] mw_age;
   logic [WAYS-1:0][TAG_W-1:0] mw_tag;

   logic               fb_we;
   logic [WIDX_W-1:0]  fb_idx;
   logic               dwe;
   logic [DADDR_W-1:0] daddr;

   logic               hit;
   logic [WAY_W-1:0]   hway, vway;
   logic [AGE_W-1:0]   best;
   logic               found_inv;
   logic               k_last;

   assign q_addr = ADDR_BITS'(cq_data.req.address);
   assign c_addr = ADDR_BITS'(cur_ff.req.address);
   assign q_set  = SET_W'((q_addr >> OFF_BITS) & (SET_COUNT - 1));
   assign c_set  = SET_W'((c_addr >> OFF_BITS) & (SET_COUNT - 1));
   assign c_tag  = TAG_W'(c_addr >> (OFF_BITS + LOG_SETS));
   assign raddr  = (state_ff == S_IDLE) ? q_set : c_set;
   assign daddr  = {ent_ff, k_ff};
   assign k_last = (k_ff == WIDX_W'(LINE_WORDS - 1));

   // first valid matching way, and the replacement victim
   always_comb begin
      hit       = 1'b0;
      hway      = '0;
      vway      = '0;
      best      = '0;
      found_inv = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (!hit && rvalid_ff[i] && rtag_ff[i] == c_tag) begin
            hit  = 1'b1;
            hway = WAY_W'(i);
         end
         if (!found_inv) begin
            if (!rvalid_ff[i]) begin
               vway      = WAY_W'(i);
               found_inv = 1'b1;
            end else if (rage_ff[i] >= best) begin
               best = rage_ff[i];
               vway = WAY_W'(i);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      ent_in   = ent_ff;
      k_in     = k_ff;
      clr_in   = clr_ff;
      cq_pop   = 1'b0;
      rq_push  = 1'b0;
      rq_data  = '0;
      fb_we    = 1'b0;
      fb_idx   = WIDX_W'(cq_data.req.word_index);
      dwe      = 1'b0;
      mwe      = 1'b0;
      waddr    = c_set;
      mw_valid = rvalid_ff;
      mw_age   = rage_ff;
      mw_tag   = rtag_ff;
      unique case (state_ff)
         S_CLR: begin
            mwe      = 1'b1;
            waddr    = clr_ff;
            mw_valid = '0;
            mw_age   = '0;
            mw_tag   = '0;
            clr_in   = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(SET_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!cq_empty) begin
               cq_pop = 1'b1;
               cur_in = cq_data;
               if (cq_data.op != OP_LOOKUP) begin
                  fb_we = 1'b1;
               end
               if (cq_data.op != OP_FILL) begin
                  state_in = S_META;
               end
            end
         end
         S_META: begin
            k_in = '0;
            if (cur_ff.op == OP_LOOKUP) begin
               if (!hit) begin
                  rq_data.kind = KIND_MISS;
                  rq_data.last = 1'b1;
                  rq_push      = !rq_full;
                  if (!rq_full) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  mwe = 1'b1;
                  for (int i = 0; i < WAYS; i++) begin
                     if (rage_ff[i] < rage_ff[hway]) begin
                        mw_age[i] = rage_ff[i] + AGE_W'(1);
                     end
                  end
                  mw_age[hway] = '0;
                  ent_in   = ENT_W'(c_set) * ENT_W'(WAYS) + ENT_W'(hway);
                  state_in = S_RD;
               end
            end else begin
               mwe = 1'b1;
               for (int i = 0; i < WAYS; i++) begin
                  if (rage_ff[i] != AGE_MAX) begin
                     mw_age[i] = rage_ff[i] + AGE_W'(1);
                  end
               end
               mw_age[vway]   = '0;
               mw_valid[vway] = 1'b1;
               mw_tag[vway]   = c_tag;
               ent_in   = ENT_W'(c_set) * ENT_W'(WAYS) + ENT_W'(vway);
               state_in = S_COPY;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            rq_data.kind           = KIND_HIT;
            rq_data.entry          = 10'(ent_ff);
            rq_data.out_word_index = 3'(k_ff);
            rq_data.out_word       = drd_ff;
            rq_data.last           = k_last;
            rq_push                = !rq_full;
            if (!rq_full) begin
               k_in     = k_ff + WIDX_W'(1);
               state_in = k_last ? S_IDLE : S_RD;
            end
         end
         S_COPY: begin
            dwe  = 1'b1;
            k_in = k_ff + WIDX_W'(1);
            if (k_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rq_data.kind  = KIND_COMMIT;
            rq_data.entry = 10'(ent_ff);
            rq_data.last  = 1'b1;
            rq_push       = !rq_full;
            if (!rq_full) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign status.clearing = (state_ff == S_CLR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ent_ff <= ent_in;
      k_ff   <= k_in;
      if (fb_we) begin
         fb_ff[fb_idx] <= cq_data.req.word_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         mvalid[waddr] <= mw_valid;
         mage[waddr]   <= mw_age;
         mtag[waddr]   <= mw_tag;
      end
      rvalid_ff <= mvalid[raddr];
      rage_ff   <= mage[raddr];
      rtag_ff   <= mtag[raddr];
   end

   always_ff @(posedge clock) begin
      if (dwe) begin
         dmem[daddr] <= fb_ff[k_ff];
      end
      drd_ff <= dmem[daddr];
   end

endmodule

FILE: rtl/set_assoc_cache_lru_store_core.sv
// Top level of the set-associative LRU cache store.
// Joins scalru_fe, the command and result queues and scalru_be; uses scalru_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  ports                  accepted when
//  request   in         push, full, req_data   push && !full
//  result    out        pop, empty, rsp_data   pop && !empty
//
//  A non-final insert word only writes the fill buffer; a lookup miss reads the set
//  metadata and returns a miss; a hit reads the data memory and sends one result per
//  word, a read and a result in turn; a commit copies the fill buffer one word a cycle.
//  Reset clears the metadata memory one set a cycle: full stays high during the pass.
//  A full result queue stalls the back end; a full command queue raises full.

module set_assoc_cache_lru_store_core
   import scalru_pkg::*;
#(
   parameter int ADDR_BITS   = ADDR_BITS_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,  // power of two
   parameter int SET_COUNT   = SET_COUNT_DEF,    // power of two
   parameter int WAYS        = WAYS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_data
);

   localparam int LINE_WORDS = BLOCK_BYTES / 8;

   logic          cq_push, cq_full, cq_pop, cq_empty;
   cmd_type       cq_wdata, cq_rdata;
   logic          rq_push, rq_full;
   rsp_type       rq_wdata;
   be_status_type be_status;

   scalru_fe #(
      .LINE_WORDS(LINE_WORDS)
   ) u_fe (
      .push    (push),
      .req_data(req_data),
      .cq_full (cq_full),
      .clearing(be_status.clearing),
      .full    (full),
      .cq_push (cq_push),
      .cq_data (cq_wdata)
   );

   scalru_fifo #(
      .W($bits(cmd_type))
   ) u_cmd_q (
      .clock(clock),
      .reset(reset),
      .push (cq_push),
      .wdata(cq_wdata),
      .full (cq_full),
      .pop  (cq_pop),
      .rdata(cq_rdata),
      .empty(cq_empty)
   );

   scalru_be #(
      .ADDR_BITS  (ADDR_BITS),
      .BLOCK_BYTES(BLOCK_BYTES),
      .SET_COUNT  (SET_COUNT),
      .WAYS       (WAYS)
   ) u_be (
      .clock   (clock),
      .reset   (reset),
      .cq_empty(cq_empty),
      .cq_data (cq_rdata),
      .cq_pop  (cq_pop),
      .rq_full (rq_full),
      .rq_push (rq_push),
      .rq_data (rq_wdata),
      .status  (be_status)
   );

   scalru_fifo #(
      .W($bits(rsp_type))
   ) u_rsp_q (
      .clock(clock),
      .reset(reset),
      .push (rq_push),
      .wdata(rq_wdata),
      .full (rq_full),
      .pop  (pop),
      .rdata(rsp_data),
      .empty(empty)
   );

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      be_status.clearing |-> full)
      else $error("request taken during clearing pass");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind != KIND_HIT) |-> rsp_data.last)
      else $error("miss or commit result without last mark");

   a_hit_last_pos: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.kind == KIND_HIT && rsp_data.last)
      |-> rsp_data.out_word_index == 3'(LINE_WORDS - 1))
      else $error("hit line closed at wrong word");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result pending after reset");

endmodule

FILE: tb/sv/set_assoc_cache_lru_store_core_test.sv
// Self-checking testbench for the set-associative LRU cache store core.
// Predicts lookups, hits and line commits per set; depends on scalru_pkg and the core.
`timescale 1ns / 1ps

module set_assoc_cache_lru_store_core_test
   import scalru_pkg::*;
();

   localparam int NSETS = 256;
   localparam int NWAYS = 4;
   localparam int NWORDS = 8;
   localparam int NENT = NSETS * NWAYS;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    pop = 1'b0;
   logic    empty;
   rsp_type rsp_data;

   set_assoc_cache_lru_store_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .pop(pop), .empty(empty), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   bit          line_valid [NENT];
   logic [33:0] line_tag [NENT];
   logic [7:0]  line_age [NENT];
   logic [63:0] line_data [NENT*NWORDS];
   logic [63:0] fill_words [NWORDS];
   bit          fill_written [NWORDS];

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   bit      hold_pop = 1'b0;
   bit      no_idle = 1'b0;
   logic [33:0] known_tags[$];
   logic [7:0]  known_sets[$];

   function automatic void predict(req_type r);
      int s, b, hit, victim, best;
      logic [33:0] tg;
      logic [7:0] ha;
      rsp_type o;
      s = r.address[13:6];
      tg = r.address[47:14];
      b = s * NWAYS;
      hit = -1;
      if (r.cmd == CMD_LOOKUP) begin
         for (int i = 0; i < NWAYS; i++)
            if (hit < 0 && line_valid[b+i] && line_tag[b+i] == tg) hit = b + i;
         if (hit < 0) begin
            o = '0; o.kind = KIND_MISS; o.last = 1'b1;
            expected_rsps.push_back(o);
            return;
         end
         ha = line_age[hit];
         for (int i = 0; i < NWAYS; i++)
            if (line_age[b+i] < ha) line_age[b+i]++;
         line_age[hit] = '0;
         for (int k = 0; k < NWORDS; k++) begin
            o.kind = KIND_HIT; o.entry = hit[9:0]; o.out_word_index = k[2:0];
            o.out_word = line_data[hit*NWORDS+k]; o.last = (k == NWORDS-1);
            expected_rsps.push_back(o);
         end
         return;
      end
      fill_words[r.word_index] = r.word_data;
      fill_written[r.word_index] = 1'b1;
      if (r.word_index != 3'(NWORDS-1)) return;
      victim = b; best = 0;
      for (int i = 0; i < NWAYS; i++) begin
         if (!line_valid[b+i]) begin
            victim = b + i;
            break;
         end
         if (line_age[b+i] >= best) begin
            best = line_age[b+i]; victim = b + i;
         end
      end
      for (int i = 0; i < NWAYS; i++)
         if (line_age[b+i] != AGE_MAX) line_age[b+i]++;
      line_age[victim] = '0;
      line_valid[victim] = 1'b1;
      line_tag[victim] = tg;
      for (int k = 0; k < NWORDS; k++) line_data[victim*NWORDS+k] = fill_words[k];
      o = '0; o.kind = KIND_COMMIT; o.entry = victim[9:0]; o.last = 1'b1;
      expected_rsps.push_back(o);
      known_tags.push_back(tg);
      known_sets.push_back(s[7:0]);
   endfunction

   // hold push high between items that follow with no gap
   task automatic send_item(req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      predict(r);
      @(negedge clock);
   endtask

   // result side: draw a stall per item, sample at the rising edge
   initial begin
      rsp_type e;
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 18);
         if (stall != 0 || hold_pop) begin
            pop <= 1'b0;
            repeat (stall) @(negedge clock);
            while (hold_pop) @(negedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.kind !== e.kind || rsp_data.entry !== e.entry ||
                rsp_data.out_word_index !== e.out_word_index ||
                rsp_data.out_word !== e.out_word || rsp_data.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
         @(negedge clock);
      end
   end

   function automatic req_type make_lookup(logic [47:0] a);
      req_type r;
      r = '0; r.cmd = CMD_LOOKUP; r.address = a;
      r.word_index = 3'($urandom); r.word_data = {$urandom, $urandom};
      return r;
   endfunction

   task automatic insert_line(logic [47:0] a);
      req_type r;
      for (int k = 0; k < NWORDS; k++) begin
         r.cmd = CMD_INSERT; r.address = a; r.word_index = k[2:0];
         r.word_data = {$urandom, $urandom};
         send_item(r);
      end
   endtask

   function automatic logic [47:0] rand_addr();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[47:0];
   endfunction

   function automatic logic [47:0] addr_of(logic [33:0] tg, logic [7:0] s);
      return {tg, s, 6'($urandom)};
   endfunction

   task automatic drain();
      push <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic test_directed();
      logic [47:0] a;
      send_item(make_lookup(48'h0));
      send_item(make_lookup(48'hFFFF_FFFF_FFFF));
      a = 48'hFFFF_FFFF_FFC0;
      insert_line(a);
      send_item(make_lookup(a));
      insert_line(48'h0);
      send_item(make_lookup(48'h3F));
      // one stray word without a commit
      begin
         req_type r;
         r = '0; r.cmd = CMD_INSERT; r.address = 48'h1234_5678_9A00;
         r.word_index = 3'd2; r.word_data = '1;
         send_item(r);
      end
   endtask

   // fill one set past its ways so replacement and ageing take effect
   task automatic test_replacement();
      logic [7:0] s;
      s = 8'd17;
      for (int i = 0; i < 6; i++) insert_line({34'(i + 5), s, 6'd0});
      for (int i = 0; i < 6; i++) send_item(make_lookup({34'(i + 5), s, 6'd0}));
      insert_line({34'd5, s, 6'd0});
      send_item(make_lookup({34'd5, s, 6'd0}));
   endtask

   // run commits back to back through one set so every way is replaced in turn
   task automatic test_age_saturation();
      logic [7:0] s;
      s = 8'd200;
      no_idle = 1'b1;
      insert_line({34'h3_FFFF_FFFF, s, 6'd0});
      for (int i = 0; i < 20; i++) begin
         req_type r;
         r.cmd = CMD_INSERT; r.address = {34'h1, s, 6'd0};
         r.word_index = 3'(NWORDS-1); r.word_data = {$urandom, $urandom};
         send_item(r);
      end
      no_idle = 1'b0;
      send_item(make_lookup({34'h3_FFFF_FFFF, s, 6'd0}));
      send_item(make_lookup({34'h1, s, 6'd0}));
   endtask

   task automatic test_backpressure();
      hold_pop = 1'b1;
      no_idle = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_pop = 1'b0;
         end
         for (int i = 0; i < 30; i++) send_item(make_lookup(rand_addr()));
      join
      no_idle = 1'b0;
      drain();
   endtask

   task automatic test_random(int n);
      int sent, pick, j;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            insert_line(known_tags.size() != 0 && $urandom_range(0, 1) ?
               addr_of(34'($urandom),
                       known_sets[$urandom_range(0, known_sets.size()-1)]) :
               {$urandom, 16'($urandom)} & 48'hFFFF_FFFF_00FF | 48'h0);
            sent += NWORDS;
         end else if (pick < 8 && known_tags.size() != 0) begin
            j = $urandom_range(0, known_tags.size()-1);
            send_item(make_lookup(addr_of(known_tags[j], known_sets[j])));
            sent++;
         end else begin
            req_type r;
            r.cmd = 1'($urandom); r.address = rand_addr();
            r.word_index = 3'($urandom_range(0, NWORDS-2)); r.word_data = {$urandom, $urandom};
            if (r.cmd == CMD_INSERT && !fill_written[r.word_index]) r.cmd = CMD_LOOKUP;
            send_item(r);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_replacement();
      drain();
      test_age_saturation();
      test_backpressure();
      test_random(216);
      drain();
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/scalru_pkg.sv
rtl/scalru_fifo.sv
rtl/scalru_fe.sv
rtl/scalru_be.sv
rtl/set_assoc_cache_lru_store_core.sv
tb/sv/set_assoc_cache_lru_store_core_test.sv
